>>> src/gmd_pkg.sv
`default_nettype none
package gmd_pkg;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_SOLVE  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [2:0] REG_GRID_HEIGHT = 3'd1;
  localparam logic [2:0] REG_START_COL   = 3'd2;
  localparam logic [2:0] REG_START_ROW   = 3'd3;
  localparam logic [2:0] REG_GOAL_COL    = 3'd4;
  localparam logic [2:0] REG_GOAL_ROW    = 3'd5;

  // Step directions, also the parent code stored for each visited cell.
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] cell_col;
    logic [5:0] cell_row;
    logic       wall_bit;
  } in_t;

  typedef struct packed {
    logic goal_found;
    logic cell_on_path;
    logic cell_visited;
  } out_t;

endpackage
`default_nettype wire

>>> src/gmd_ram.sv
`default_nettype none
module gmd_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> src/gmd_step.sv
`default_nettype none
// Moves one cell in a direction (or against it) and checks the bounds.
module gmd_step #(
  parameter int CW = 6,
  parameter int RW = 6,
  parameter int EW = 8
) (
  input  wire logic [CW-1:0] col,
  input  wire logic [RW-1:0] row,
  input  wire logic [1:0]    dir,
  input  wire logic          back,
  input  wire logic [EW-1:0] lim_col,
  input  wire logic [EW-1:0] lim_row,
  output logic      [CW-1:0] ncol,
  output logic      [RW-1:0] nrow,
  output logic               ok
);

  logic [1:0]    eff;
  logic [EW-1:0] ce;
  logic [EW-1:0] re;

  always_comb begin
    // Going back along a step is the opposite direction: flip the low bit.
    eff  = dir ^ {1'b0, back};
    ce   = EW'(col);
    re   = EW'(row);
    ncol = col;
    nrow = row;
    ok   = 1'b0;
    case (eff)
      gmd_pkg::DIR_UP: begin
        nrow = row - RW'(1);
        ok   = (row != '0);
      end
      gmd_pkg::DIR_DOWN: begin
        nrow = row + RW'(1);
        ok   = (re + EW'(1)) < lim_row;
      end
      gmd_pkg::DIR_LEFT: begin
        ncol = col - CW'(1);
        ok   = (col != '0);
      end
      default: begin
        ncol = col + CW'(1);
        ok   = (ce + EW'(1)) < lim_col;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> src/grid_maze_dfs_solver.sv
`default_nettype none
// Channel | Direction | Handshake             | Content
// in      | input     | in_valid / in_ready   | in_data: op, cell_col, cell_row, wall_bit
// out     | output    | out_valid / out_ready | out_data: goal_found, cell_on_path, cell_visited
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
// A wall write goes to the map as it is accepted; a read passes through S_RD.
// A solve first clears the marks at all 2^(CW+RW) addresses (4096 at 64 x 64),
// then searches, popping each cell (S_POP, S_POPW) and trying each neighbor
// (S_NB, plus S_NBW for one inside the grid) on the shared step unit and the
// single read port of each map, then retraces the path (S_RT, S_RTW per cell).
// After reset a clearing pass over all 2^(CW+RW) addresses empties all maps;
// no request is accepted meanwhile. One request is worked on at a time; a
// finished result waits in the output register, and the next request is
// accepted only once that result leaves, at the earliest in the same cycle.
module grid_maze_dfs_solver #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire gmd_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output gmd_pkg::out_t      out_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [6:0]    cfg_data
);

  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int AW    = CW + RW;
  localparam int DEPTH = 1 << AW;
  localparam int NCELL = MAX_COLS * MAX_ROWS;
  localparam int MW    = (CW > RW) ? CW : RW;
  localparam int EW    = ((MW > 7) ? MW : 7) + 1;
  localparam int DPW   = AW + 1;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD, S_START, S_POP, S_POPW, S_NB, S_NBW, S_RT, S_RTW
  } state_t;

  state_t state;

  // Configuration registers.
  logic [6:0] grid_width, grid_height;
  logic [5:0] start_col, start_row, goal_col, goal_row;

  // Sequencer registers.
  logic [AW-1:0]  clr_addr;
  logic           clr_wall;
  logic           solving;
  logic [DPW-1:0] depth;
  logic [DPW-1:0] guard;
  logic [CW-1:0]  cur_c, nb_c;
  logic [RW-1:0]  cur_r, nb_r;
  logic [1:0]     dir;
  logic           found;
  logic           rd_inside;

  // Effective grid size, saturated to the map size.
  logic [EW-1:0] w_eff, h_eff;
  assign w_eff = (EW'(grid_width) > EW'(MAX_COLS)) ? EW'(MAX_COLS) : EW'(grid_width);
  assign h_eff = (EW'(grid_height) > EW'(MAX_ROWS)) ? EW'(MAX_ROWS) : EW'(grid_height);

  logic in_fire, out_fire;
  assign in_ready  = (state == S_IDLE) && (!out_valid || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign cfg_ready = 1'b1;

  // Request cell address and map bound check.
  logic          in_inside;
  logic [AW-1:0] in_addr;
  assign in_inside = (EW'(in_data.cell_col) < EW'(MAX_COLS)) &&
                     (EW'(in_data.cell_row) < EW'(MAX_ROWS));
  assign in_addr = {RW'(in_data.cell_row), CW'(in_data.cell_col)};

  logic start_in, at_goal, at_start;
  assign start_in = (EW'(start_col) < w_eff) && (EW'(start_row) < h_eff);
  assign at_goal  = (EW'(cur_c) == EW'(goal_col)) && (EW'(cur_r) == EW'(goal_row));
  assign at_start = (EW'(cur_c) == EW'(start_col)) && (EW'(cur_r) == EW'(start_row));

  logic [CW-1:0] sc_c;
  logic [RW-1:0] sc_r;
  assign sc_c = CW'(start_col);
  assign sc_r = RW'(start_row);

  // Memories.
  logic          wall_we, wall_wdata, wall_rdata;
  logic [AW-1:0] wall_waddr, wall_raddr;
  logic          vis_we;
  logic [2:0]    vis_wdata, vis_rdata;
  logic [AW-1:0] vis_waddr, vis_raddr;
  logic          path_we, path_wdata, path_rdata;
  logic [AW-1:0] path_waddr, path_raddr;
  logic          stk_we;
  logic [AW-1:0] stk_wdata, stk_rdata, stk_waddr, stk_raddr;

  gmd_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_wall (
    .clk(clk), .we(wall_we), .waddr(wall_waddr), .wdata(wall_wdata),
    .raddr(wall_raddr), .rdata(wall_rdata)
  );
  gmd_ram #(.WIDTH(3), .DEPTH(DEPTH)) u_vis (
    .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
    .raddr(vis_raddr), .rdata(vis_rdata)
  );
  gmd_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_path (
    .clk(clk), .we(path_we), .waddr(path_waddr), .wdata(path_wdata),
    .raddr(path_raddr), .rdata(path_rdata)
  );
  gmd_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  // The one step unit: forward neighbor moves while searching, and the
  // backward parent move while retracing.
  logic          st_back, st_ok;
  logic [1:0]    st_dir;
  logic [EW-1:0] st_lc, st_lr;
  logic [CW-1:0] st_c;
  logic [RW-1:0] st_r;

  assign st_back = (state == S_RTW);
  assign st_dir  = st_back ? vis_rdata[1:0] : dir;
  assign st_lc   = st_back ? EW'(MAX_COLS) : w_eff;
  assign st_lr   = st_back ? EW'(MAX_ROWS) : h_eff;

  gmd_step #(.CW(CW), .RW(RW), .EW(EW)) u_step (
    .col(cur_c), .row(cur_r), .dir(st_dir), .back(st_back),
    .lim_col(st_lc), .lim_row(st_lr), .ncol(st_c), .nrow(st_r), .ok(st_ok)
  );

  logic nb_free;
  assign nb_free = !wall_rdata && !vis_rdata[2];

  // Memory ports, steered by the sequencer state.
  always_comb begin
    wall_we    = 1'b0;
    wall_waddr = in_addr;
    wall_wdata = in_data.wall_bit;
    wall_raddr = {st_r, st_c};
    vis_we     = 1'b0;
    vis_waddr  = {nb_r, nb_c};
    vis_wdata  = {1'b1, dir};
    vis_raddr  = {st_r, st_c};
    path_we    = 1'b0;
    path_waddr = {st_r, st_c};
    path_wdata = 1'b1;
    path_raddr = in_addr;
    stk_we     = 1'b0;
    stk_waddr  = depth[AW-1:0];
    stk_wdata  = {nb_r, nb_c};
    stk_raddr  = AW'(depth - DPW'(1));
    case (state)
      S_CLR: begin
        wall_we    = clr_wall;
        wall_waddr = clr_addr;
        wall_wdata = 1'b0;
        vis_we     = 1'b1;
        vis_waddr  = clr_addr;
        vis_wdata  = '0;
        path_we    = 1'b1;
        path_waddr = clr_addr;
        path_wdata = 1'b0;
      end
      S_IDLE: begin
        wall_we   = in_fire && (in_data.op == gmd_pkg::OP_WRITE) && in_inside;
        vis_raddr = in_addr;
      end
      S_START: begin
        vis_we    = start_in;
        vis_waddr = {sc_r, sc_c};
        vis_wdata = {1'b1, gmd_pkg::DIR_UP};
        stk_we    = start_in;
        stk_waddr = '0;
        stk_wdata = {sc_r, sc_c};
      end
      S_NBW: begin
        vis_we = nb_free;
        stk_we = nb_free && (depth < DPW'(NCELL));
      end
      S_RT: begin
        vis_raddr  = {cur_r, cur_c};
        path_we    = at_start || (guard >= DPW'(NCELL));
        path_waddr = {sc_r, sc_c};
      end
      S_RTW: begin
        path_we = st_ok;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      clr_addr    <= '0;
      clr_wall    <= 1'b1;
      solving     <= 1'b0;
      depth       <= '0;
      found       <= 1'b0;
      out_valid   <= 1'b0;
      grid_width  <= 7'd64;
      grid_height <= 7'd64;
      start_col   <= 6'd0;
      start_row   <= 6'd0;
      goal_col    <= 6'd63;
      goal_row    <= 6'd63;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gmd_pkg::REG_GRID_WIDTH:  grid_width  <= cfg_data;
          gmd_pkg::REG_GRID_HEIGHT: grid_height <= cfg_data;
          gmd_pkg::REG_START_COL:   start_col   <= cfg_data[5:0];
          gmd_pkg::REG_START_ROW:   start_row   <= cfg_data[5:0];
          gmd_pkg::REG_GOAL_COL:    goal_col    <= cfg_data[5:0];
          gmd_pkg::REG_GOAL_ROW:    goal_row    <= cfg_data[5:0];
          default: begin
          end
        endcase
      end
      if (out_fire) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            clr_wall <= 1'b0;
            state    <= solving ? S_START : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            rd_inside <= in_inside;
            case (in_data.op)
              gmd_pkg::OP_SOLVE: begin
                solving <= 1'b1;
                found   <= 1'b0;
                state   <= S_CLR;
              end
              gmd_pkg::OP_READ: begin
                state <= S_RD;
              end
              default: begin
                out_valid <= 1'b1;
                out_data  <= '{goal_found: found, cell_on_path: 1'b0, cell_visited: 1'b0};
              end
            endcase
          end
        end
        S_RD: begin
          out_valid <= 1'b1;
          out_data  <= '{goal_found: found, cell_on_path: path_rdata && rd_inside,
                         cell_visited: vis_rdata[2] && rd_inside};
          state     <= S_IDLE;
        end
        S_START: begin
          // A start cell outside the grid ends the search at once.
          depth <= start_in ? DPW'(1) : '0;
          state <= S_POP;
        end
        S_POP: begin
          if (depth == '0) begin
            solving   <= 1'b0;
            out_valid <= 1'b1;
            out_data  <= '{goal_found: found, cell_on_path: 1'b0, cell_visited: 1'b0};
            state     <= S_IDLE;
          end else begin
            depth <= depth - DPW'(1);
            state <= S_POPW;
          end
        end
        S_POPW: begin
          cur_c <= stk_rdata[CW-1:0];
          cur_r <= stk_rdata[AW-1:CW];
          dir   <= gmd_pkg::DIR_UP;
          state <= S_NB;
        end
        S_NB: begin
          if (at_goal) begin
            found <= 1'b1;
            guard <= '0;
            state <= S_RT;
          end else if (st_ok) begin
            nb_c  <= st_c;
            nb_r  <= st_r;
            state <= S_NBW;
          end else begin
            dir   <= dir + 2'd1;
            state <= (dir == gmd_pkg::DIR_RIGHT) ? S_POP : S_NB;
          end
        end
        S_NBW: begin
          if (nb_free && (depth < DPW'(NCELL))) begin
            depth <= depth + DPW'(1);
          end
          dir   <= dir + 2'd1;
          state <= (dir == gmd_pkg::DIR_RIGHT) ? S_POP : S_NB;
        end
        S_RT: begin
          // The retrace starts at the goal, which S_NB left in cur_c/cur_r.
          if (at_start || (guard >= DPW'(NCELL))) begin
            solving   <= 1'b0;
            out_valid <= 1'b1;
            out_data  <= '{goal_found: 1'b1, cell_on_path: 1'b0, cell_visited: 1'b0};
            state     <= S_IDLE;
          end else begin
            state <= S_RTW;
          end
        end
        S_RTW: begin
          if (st_ok) begin
            cur_c <= st_c;
            cur_r <= st_r;
            guard <= guard + DPW'(1);
            state <= S_RT;
          end else begin
            // A parent step off the map stops the retrace without marking start.
            solving   <= 1'b0;
            out_valid <= 1'b1;
            out_data  <= '{goal_found: 1'b1, cell_on_path: 1'b0, cell_visited: 1'b0};
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/gmd_checker.sv
`default_nettype none
module gmd_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire gmd_pkg::in_t  in_data,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire gmd_pkg::out_t out_data,
  input wire logic          cfg_valid,
  input wire logic          cfg_ready,
  input wire logic [2:0]    cfg_index,
  input wire logic [6:0]    cfg_data
);

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!out_valid || out_ready))
    else $error("request accepted while a result is blocked");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (in_data.op == gmd_pkg::OP_SOLVE ||
     in_data.op == gmd_pkg::OP_READ)) |=> !in_ready)
    else $error("ready right after an accepted solve or read request");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  a_write_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.op != gmd_pkg::OP_SOLVE &&
     in_data.op != gmd_pkg::OP_READ) |=>
    (out_valid && !out_data.cell_on_path && !out_data.cell_visited))
    else $error("write result missing or carries marks");

endmodule

bind grid_maze_dfs_solver gmd_checker u_gmd_checker (.*);
`default_nettype wire

>>> tb/sv/tb.sv
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS = 64;
  localparam int ROWS = 64;
  localparam int CELLS = COLS * ROWS;

  // One line of the directed stimulus: either a register write or a request.
  // Where the expected result is obvious it is typed in and used instead of
  // the predicted one.
  typedef struct {
    bit            is_cfg;
    gmd_pkg::in_t  req;
    logic [2:0]    idx;
    logic [6:0]    val;
    bit            typed;
    gmd_pkg::out_t want;
  } stim_row_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_ready;
  gmd_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  gmd_pkg::out_t out_data;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [2:0]    cfg_index = '0;
  logic [6:0]    cfg_data = '0;

  always #5 clk = ~clk;

  grid_maze_dfs_solver i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the maze and of the marks left by the latest search.
  bit         wall_m[CELLS];
  bit         seen_m[CELLS];
  logic [1:0] from_m[CELLS];
  bit         route_m[CELLS];
  int         dfs_stack[CELLS];
  bit         found_q;
  logic [6:0] width_q, height_q;
  logic [5:0] start_c, start_r, goal_c, goal_r;

  gmd_pkg::out_t result_q[$];
  stim_row_t     plan[$];
  int            errors = 0;
  int            n_sent = 0;
  int            n_solves = 0;
  int            n_found = 0;
  int            n_results = 0;
  int            gap_pct = 19;
  int            stall_pct = 66;
  bit            random_on = 1'b0;

  // Column and row offset of one step in a given direction.
  function automatic int step_dc(logic [1:0] d);
    return (d == gmd_pkg::DIR_LEFT) ? -1 : (d == gmd_pkg::DIR_RIGHT) ? 1 : 0;
  endfunction

  function automatic int step_dr(logic [1:0] d);
    return (d == gmd_pkg::DIR_UP) ? -1 : (d == gmd_pkg::DIR_DOWN) ? 1 : 0;
  endfunction

  // Walk the parent chain back from the goal, marking ancestors on the route.
  // A chain that leaves the map stops without marking the start.
  function automatic void mark_route();
    int c, r, pc, pr, guard;
    logic [1:0] d;
    c = goal_c;
    r = goal_r;
    guard = 0;
    while ((c != start_c || r != start_r) && guard < CELLS) begin
      d = from_m[r * COLS + c];
      pc = c - step_dc(d);
      pr = r - step_dr(d);
      if (pc < 0 || pr < 0 || pc >= COLS || pr >= ROWS) return;
      c = pc;
      r = pr;
      route_m[r * COLS + c] = 1'b1;
      guard++;
    end
    route_m[start_r * COLS + start_c] = 1'b1;
  endfunction

  // Depth-first search from the start cell, neighbors in up, down, left,
  // right order, each cell marked seen when it is pushed.
  function automatic void search_maze();
    int w, h, depth, pos, c, r, nc, nr, n;
    w = (width_q > COLS) ? COLS : width_q;
    h = (height_q > ROWS) ? ROWS : height_q;
    foreach (seen_m[i]) begin
      seen_m[i] = 1'b0;
      from_m[i] = gmd_pkg::DIR_UP;
      route_m[i] = 1'b0;
    end
    found_q = 1'b0;
    if (start_c >= w || start_r >= h) return;
    pos = start_r * COLS + start_c;
    seen_m[pos] = 1'b1;
    dfs_stack[0] = pos;
    depth = 1;
    while (depth != 0) begin
      depth--;
      pos = dfs_stack[depth];
      c = pos % COLS;
      r = pos / COLS;
      if (c == goal_c && r == goal_r) begin
        found_q = 1'b1;
        mark_route();
        return;
      end
      for (int d = 0; d < 4; d++) begin
        nc = c + step_dc(d[1:0]);
        nr = r + step_dr(d[1:0]);
        if (nc < 0 || nr < 0 || nc >= w || nr >= h) continue;
        n = nr * COLS + nc;
        if (wall_m[n] || seen_m[n]) continue;
        seen_m[n] = 1'b1;
        from_m[n] = d[1:0];
        // A full stack drops the push; the mark stays.
        if (depth < CELLS) begin
          dfs_stack[depth] = n;
          depth++;
        end
      end
    end
  endfunction

  function automatic gmd_pkg::out_t predict_result(gmd_pkg::in_t req);
    gmd_pkg::out_t res;
    int idx;
    res = '0;
    idx = req.cell_row * COLS + req.cell_col;
    case (req.op)
      gmd_pkg::OP_WRITE: wall_m[idx] = req.wall_bit;
      gmd_pkg::OP_SOLVE: search_maze();
      gmd_pkg::OP_READ: begin
        res.cell_on_path = route_m[idx];
        res.cell_visited = seen_m[idx];
      end
      default: ;
    endcase
    res.goal_found = found_q;
    return res;
  endfunction

  // Offer one request, holding it until accepted. Valid stays high on return
  // so that back-to-back requests need no second assignment in one step.
  task automatic offer_request(gmd_pkg::in_t req, bit typed, gmd_pkg::out_t want);
    gmd_pkg::out_t res;
    if (n_sent > 70) begin
      gap_pct = 0;
      stall_pct = 0;
    end else if (n_sent > 40) begin
      gap_pct = 66;
      stall_pct = 19;
    end
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    res = predict_result(req);
    if (req.op == gmd_pkg::OP_SOLVE) begin
      n_solves++;
      n_found += found_q;
    end
    result_q.push_back(typed ? want : res);
    n_sent++;
  endtask

  // Register writes wait until every outstanding result has come back.
  task automatic write_reg(logic [2:0] idx, int val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[6:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      gmd_pkg::REG_GRID_WIDTH:  width_q = val[6:0];
      gmd_pkg::REG_GRID_HEIGHT: height_q = val[6:0];
      gmd_pkg::REG_START_COL:   start_c = val[5:0];
      gmd_pkg::REG_START_ROW:   start_r = val[5:0];
      gmd_pkg::REG_GOAL_COL:    goal_c = val[5:0];
      gmd_pkg::REG_GOAL_ROW:    goal_r = val[5:0];
      default: ;
    endcase
  endtask

  function automatic void add_req(logic [1:0] op, int c, int r, bit wb,
                                  bit typed = 1'b0, gmd_pkg::out_t want = '0);
    stim_row_t row;
    row = '{is_cfg: 1'b0, req: '{op, c[5:0], r[5:0], wb}, idx: '0, val: '0,
            typed: typed, want: want};
    plan.push_back(row);
  endfunction

  function automatic void add_cfg(logic [2:0] idx, int val);
    stim_row_t row;
    row = '{is_cfg: 1'b1, req: '0, idx: idx, val: val[6:0], typed: 1'b0,
            want: '0};
    plan.push_back(row);
  endfunction

  function automatic gmd_pkg::in_t rand_req(logic [1:0] op, int w, int h);
    gmd_pkg::in_t req;
    req.op = op;
    req.wall_bit = $urandom_range(99) < 35;
    // Mostly cells of the grid in use; now and then anywhere in the map.
    if ($urandom_range(9) == 0 || w == 0 || h == 0) begin
      req.cell_col = 6'($urandom);
      req.cell_row = 6'($urandom);
    end else begin
      req.cell_col = 6'($urandom_range(w - 1));
      req.cell_row = 6'($urandom_range(h - 1));
    end
    return req;
  endfunction

  // Receiver: compare each accepted result with the oldest expectation.
  // Once the random part starts it holds off for a long stretch so that
  // the block backs up and stops taking requests.
  initial begin
    gmd_pkg::out_t want;
    int   hold;
    bit   held;
    hold = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        n_results++;
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          errors++;
        end else begin
          want = result_q.pop_front();
          if (out_data.goal_found !== want.goal_found ||
              out_data.cell_on_path !== want.cell_on_path ||
              out_data.cell_visited !== want.cell_visited) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, out_data);
            errors++;
          end
        end
      end
      if (random_on && !held) begin
        held = 1'b1;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    #40ms;
    $display("grid_maze_dfs_solver test failed");
    $finish;
  end

  initial begin
    int            w, h;
    gmd_pkg::out_t zero_res;
    gmd_pkg::out_t zero_found;
    zero_res = '0;
    zero_found = '{goal_found: 1'b1, cell_on_path: 1'b0, cell_visited: 1'b0};
    width_q = 7'd64;
    height_q = 7'd64;
    start_c = 6'd0;
    start_r = 6'd0;
    goal_c = 6'd63;
    goal_r = 6'd63;

    // Reset state: nothing is marked and nothing has been found.
    add_req(gmd_pkg::OP_READ, 0, 0, 1'b0, 1'b1, zero_res);
    add_req(gmd_pkg::OP_READ, 63, 63, 1'b1, 1'b1, zero_res);
    // The unused op code behaves as a write that changes nothing.
    add_req(gmd_pkg::OP_UNUSED, 63, 63, 1'b1, 1'b1, zero_res);
    add_req(gmd_pkg::OP_WRITE, 63, 0, 1'b1, 1'b1, zero_res);
    // A wall on the start cell does not stop the search.
    add_req(gmd_pkg::OP_WRITE, 0, 0, 1'b1, 1'b1, zero_res);
    add_req(gmd_pkg::OP_SOLVE, 0, 0, 1'b0);
    add_req(gmd_pkg::OP_READ, 0, 0, 1'b0);
    add_req(gmd_pkg::OP_READ, 63, 63, 1'b0, 1'b1, '{1'b1, 1'b0, 1'b1});
    // A tiny grid with walls on the start cell and at column 1, row 0: the route bends around them.
    add_cfg(gmd_pkg::REG_GRID_WIDTH, 2);
    add_cfg(gmd_pkg::REG_GRID_HEIGHT, 2);
    add_cfg(gmd_pkg::REG_GOAL_COL, 1);
    add_cfg(gmd_pkg::REG_GOAL_ROW, 1);
    add_req(gmd_pkg::OP_WRITE, 1, 0, 1'b1, 1'b1, zero_found);
    add_req(gmd_pkg::OP_SOLVE, 0, 0, 1'b0);
    add_req(gmd_pkg::OP_READ, 0, 1, 1'b0);
    add_req(gmd_pkg::OP_READ, 1, 1, 1'b0);
    // Goal equal to start is found at once and the start is on the route.
    add_cfg(gmd_pkg::REG_GOAL_COL, 0);
    add_cfg(gmd_pkg::REG_GOAL_ROW, 0);
    add_req(gmd_pkg::OP_SOLVE, 0, 0, 1'b0, 1'b1, zero_found);
    add_req(gmd_pkg::OP_READ, 0, 0, 1'b0, 1'b1, '{1'b1, 1'b1, 1'b1});
    // Start outside the grid in use: nothing is found or marked.
    add_cfg(gmd_pkg::REG_START_COL, 5);
    add_req(gmd_pkg::OP_SOLVE, 0, 0, 1'b0, 1'b1, zero_res);
    add_req(gmd_pkg::OP_READ, 0, 0, 1'b0, 1'b1, zero_res);
    // Zero width holds no cell at all.
    add_cfg(gmd_pkg::REG_START_COL, 0);
    add_cfg(gmd_pkg::REG_GRID_WIDTH, 0);
    add_req(gmd_pkg::OP_SOLVE, 0, 0, 1'b0, 1'b1, zero_res);
    // Oversized width saturates; the goal sits on a wall in a single row.
    add_cfg(gmd_pkg::REG_GRID_WIDTH, 127);
    add_cfg(gmd_pkg::REG_GRID_HEIGHT, 1);
    add_cfg(gmd_pkg::REG_GOAL_COL, 63);
    add_req(gmd_pkg::OP_SOLVE, 0, 0, 1'b0);
    add_req(gmd_pkg::OP_READ, 62, 0, 1'b0);
    // Goal below the grid in use is never reached.
    add_cfg(gmd_pkg::REG_GOAL_ROW, 5);
    add_req(gmd_pkg::OP_SOLVE, 0, 0, 1'b0, 1'b1, zero_res);
    add_req(gmd_pkg::OP_READ, 63, 0, 1'b0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].idx, int'(plan[i].val));
      else offer_request(plan[i].req, plan[i].typed, plan[i].want);
    end

    // Random part: each round sets a maze shape, draws some walls, solves
    // and reads back marks. Most rounds use small grids to keep solves short;
    // one round searches the full map.
    for (int rnd = 0; rnd < 10; rnd++) begin
      if (rnd == 6) begin
        w = 64;
        h = 64;
      end else begin
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 8);
      end
      write_reg(gmd_pkg::REG_GRID_WIDTH, (rnd == 2) ? 100 : w);
      write_reg(gmd_pkg::REG_GRID_HEIGHT, (rnd == 4) ? 0 : h);
      if (rnd == 4) h = 0;
      write_reg(gmd_pkg::REG_START_COL, $urandom_range(w - 1));
      write_reg(gmd_pkg::REG_START_ROW, (h == 0) ? 0 : $urandom_range(h - 1));
      write_reg(gmd_pkg::REG_GOAL_COL,
                ($urandom_range(9) == 0) ? $urandom : $urandom_range(w - 1));
      write_reg(gmd_pkg::REG_GOAL_ROW, (h == 0) ? $urandom : $urandom_range(h - 1));
      // The receiver's long hold starts here, while requests keep coming.
      random_on = 1'b1;
      repeat ($urandom_range(2, 5))
        offer_request(rand_req(gmd_pkg::OP_WRITE, w, h), 1'b0, '0);
      if ($urandom_range(3) == 0)
        offer_request(rand_req(gmd_pkg::OP_UNUSED, w, h), 1'b0, '0);
      offer_request(rand_req(gmd_pkg::OP_SOLVE, w, h), 1'b0, '0);
      repeat ($urandom_range(2, 4))
        offer_request(rand_req(gmd_pkg::OP_READ, w, h), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (result_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Sent %0d requests, %0d solves of which %0d reached the goal.",
             n_sent, n_solves, n_found);
    $display("Checked %0d results across grid shapes from empty to full size.",
             n_results);
    if (errors == 0) begin
      $display("grid_maze_dfs_solver test passed");
    end else begin
      $display("grid_maze_dfs_solver test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
